/* sv/armt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// armt_pkg
// Shared types and codes for the address region map table.
// ----------------------------------------------------------------------------
package armt_pkg;

   localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_MAP    = 3'd1;
   localparam logic [2:0] CMD_UNMAP  = 3'd2;
   localparam logic [2:0] CMD_LOOKUP = 3'd3;
   localparam logic [2:0] CMD_CHECK  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISS    = 2'd1;
   localparam logic [1:0] ST_OVERLAP = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_MAP,
      OP_UNMAP,
      OP_LOOKUP,
      OP_CHECK,
      OP_NOP,
      OP_BAD
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD,
      S_MAP_SCAN,
      S_MAP_WR,
      S_UM_COUNT,
      S_UM_CUT,
      S_UM_SPLIT,
      S_LOOK,
      S_CHK,
      S_BND,
      S_OUT
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] addr;
      logic [63:0] last;
      logic [63:0] pbase;
      logic [31:0] vol;
      logic        space;
   } item_type;

endpackage

/* sv/armt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// armt_front
// Accepts requests, classifies them and works out the last address.
// ----------------------------------------------------------------------------
module armt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_command,
   input  logic [63:0]         req_addr_start,
   input  logic [63:0]         req_length,
   input  logic [63:0]         req_phys_base,
   input  logic [31:0]         req_volume,
   input  logic                req_space,
   output logic                q_push,
   output armt_pkg::item_type  q_item,
   input  logic                q_full
);

   logic               stage_valid_ff, stage_valid_in;
   armt_pkg::item_type stage_ff, stage_in;
   logic [64:0]        sum;
   logic               len_zero, ovf, accept;

   assign q_push    = stage_valid_ff && !q_full;
   assign req_stall = stage_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_item    = stage_ff;

   always_comb begin
      sum      = {1'b0, req_addr_start} + {1'b0, req_length};
      len_zero = (req_length == 64'd0);
      ovf      = !len_zero && sum[64] && (sum[63:0] != 64'd0);
      stage_in.addr  = req_addr_start;
      stage_in.pbase = req_phys_base;
      stage_in.vol   = req_volume;
      stage_in.space = req_space;
      stage_in.last  = len_zero ? req_addr_start : (sum[63:0] - 64'd1);
      if (ovf) begin
         stage_in.last = armt_pkg::U64_MAX;
      end
      unique case (req_command)
         armt_pkg::CMD_ADD: begin
            stage_in.op = len_zero ? armt_pkg::OP_NOP :
                          (ovf ? armt_pkg::OP_BAD : armt_pkg::OP_ADD);
         end
         armt_pkg::CMD_MAP: begin
            stage_in.op = len_zero ? armt_pkg::OP_NOP :
                          (ovf ? armt_pkg::OP_BAD : armt_pkg::OP_MAP);
         end
         armt_pkg::CMD_UNMAP: begin
            stage_in.op = len_zero ? armt_pkg::OP_NOP : armt_pkg::OP_UNMAP;
         end
         armt_pkg::CMD_LOOKUP: begin
            stage_in.op = armt_pkg::OP_LOOKUP;
         end
         armt_pkg::CMD_CHECK: begin
            stage_in.op = ovf ? armt_pkg::OP_BAD : armt_pkg::OP_CHECK;
         end
         default: begin
            stage_in.op = armt_pkg::OP_BAD;
         end
      endcase
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (q_push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

/* sv/armt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// armt_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module armt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  armt_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output armt_pkg::item_type  item
);

   armt_pkg::item_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign item  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/armt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// armt_back
// Table sequencer: walks the region tables one entry per cycle; an unmap that splits a region adds an extra split step.
// ----------------------------------------------------------------------------
module armt_back #(
   parameter int N = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  armt_pkg::item_type  q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic                rsp_hit,
   output logic [63:0]         rsp_region_low,
   output logic [63:0]         rsp_region_high,
   output logic [63:0]         rsp_phys_addr,
   output logic [31:0]         rsp_region_volume,
   output logic [4:0]          rsp_region_count,
   output logic [63:0]         rsp_span_bytes
);

   localparam int IW = $clog2(N);
   localparam int CW = $clog2(N + 1);

   logic [63:0] vlow [N];
   logic [63:0] vhigh [N];
   logic [63:0] vpb [N];
   logic [31:0] vvol [N];
   logic [63:0] plow [N];
   logic [63:0] phigh [N];
   logic [N-1:0] vvalid_ff, vvalid_in, pvalid_ff, pvalid_in, snap_ff, snap_in;

   armt_pkg::state_type state_ff, state_nx;
   armt_pkg::item_type  item_ff, item_in;
   logic [IW-1:0] idx_ff, idx_in, idx_next;
   logic [1:0]    status_ff, status_in;
   logic          hit_ff, hit_in;
   logic [63:0]   rlo_ff, rlo_in, rhi_ff, rhi_in, paddr_ff, paddr_in;
   logic [31:0]   rvol_ff, rvol_in;
   logic [CW-1:0] need_ff, need_in, avail_ff, avail_in, need_nx, avail_nx;
   logic [CW-1:0] step_ff, step_in, cnt_ff, cnt_in;
   logic [63:0]   cur_ff, cur_in, lo_min_ff, lo_min_in, hi_max_ff, hi_max_in;
   logic [63:0]   sv_lo_ff, sv_lo_in, sv_pb_ff, sv_pb_in;

   logic          v_we, p_we;
   logic [IW-1:0] v_wa, p_wa;
   logic [63:0]   v_wlo, v_whi, v_wpb;
   logic [31:0]   v_wvol;

   logic          vfree_found, pfree_found;
   logic [IW-1:0] vfree_idx, pfree_idx;

   logic          rv, cv, last_idx, out_free, load;
   logic [63:0]   rl, rh, rpb, cl, ch;
   logic [31:0]   rvl;
   logic          um_hit, split, look_hit, c_hit, c_done;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    o_status_ff;
   logic          o_hit_ff;
   logic [63:0]   o_rlo_ff, o_rhi_ff, o_paddr_ff, o_span_ff;
   logic [31:0]   o_rvol_ff;
   logic [4:0]    o_cnt_ff;

   assign rv  = vvalid_ff[idx_ff];
   assign rl  = vlow[idx_ff];
   assign rh  = vhigh[idx_ff];
   assign rpb = vpb[idx_ff];
   assign rvl = vvol[idx_ff];
   assign cv  = item_ff.space ? pvalid_ff[idx_ff] : vvalid_ff[idx_ff];
   assign cl  = item_ff.space ? plow[idx_ff] : vlow[idx_ff];
   assign ch  = item_ff.space ? phigh[idx_ff] : vhigh[idx_ff];

   assign last_idx = (idx_ff == IW'(N - 1));
   assign idx_next = last_idx ? '0 : idx_ff + IW'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      vfree_found = 1'b0;
      vfree_idx   = '0;
      pfree_found = 1'b0;
      pfree_idx   = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (!vvalid_ff[i]) begin
            vfree_found = 1'b1;
            vfree_idx   = IW'(i);
         end
         if (!pvalid_ff[i]) begin
            pfree_found = 1'b1;
            pfree_idx   = IW'(i);
         end
      end
   end

   always_comb begin
      avail_nx = avail_ff + CW'(!rv);
      need_nx  = need_ff + CW'(rv && rl < item_ff.addr && rh > item_ff.last);
      um_hit   = snap_ff[idx_ff] && !(rl > item_ff.last || rh < item_ff.addr);
      split    = um_hit && rh > item_ff.last && rl < item_ff.addr;
      look_hit = rv && item_ff.addr >= rl && item_ff.addr <= rh;
      c_hit    = cv && cur_ff >= cl && cur_ff <= ch;
      c_done   = (ch >= item_ff.last) || (step_ff == CW'(N));
   end

   // next state
   always_comb begin
      state_nx = state_ff;
      unique case (state_ff)
         armt_pkg::S_IDLE: begin
            if (q_valid) begin
               unique case (q_item.op)
                  armt_pkg::OP_ADD:    state_nx = armt_pkg::S_ADD;
                  armt_pkg::OP_MAP:    state_nx = armt_pkg::S_MAP_SCAN;
                  armt_pkg::OP_UNMAP:  state_nx = armt_pkg::S_UM_COUNT;
                  armt_pkg::OP_LOOKUP: state_nx = armt_pkg::S_LOOK;
                  armt_pkg::OP_CHECK:  state_nx = armt_pkg::S_CHK;
                  default:             state_nx = armt_pkg::S_BND;
               endcase
            end
         end
         armt_pkg::S_ADD: state_nx = armt_pkg::S_BND;
         armt_pkg::S_MAP_SCAN: begin
            if (last_idx) state_nx = armt_pkg::S_MAP_WR;
         end
         armt_pkg::S_MAP_WR: state_nx = armt_pkg::S_BND;
         armt_pkg::S_UM_COUNT: begin
            if (last_idx) begin
               state_nx = (need_nx > avail_nx) ? armt_pkg::S_BND : armt_pkg::S_UM_CUT;
            end
         end
         armt_pkg::S_UM_CUT: begin
            if (split) begin
               state_nx = armt_pkg::S_UM_SPLIT;
            end else if (last_idx) begin
               state_nx = armt_pkg::S_BND;
            end
         end
         armt_pkg::S_UM_SPLIT: begin
            state_nx = last_idx ? armt_pkg::S_BND : armt_pkg::S_UM_CUT;
         end
         armt_pkg::S_LOOK: begin
            if (look_hit || last_idx) state_nx = armt_pkg::S_BND;
         end
         armt_pkg::S_CHK: begin
            if (c_hit ? c_done : last_idx) state_nx = armt_pkg::S_BND;
         end
         armt_pkg::S_BND: begin
            if (last_idx) state_nx = armt_pkg::S_OUT;
         end
         armt_pkg::S_OUT: begin
            if (out_free) state_nx = armt_pkg::S_IDLE;
         end
         default: state_nx = armt_pkg::S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      item_in   = item_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      hit_in    = hit_ff;
      rlo_in    = rlo_ff;
      rhi_in    = rhi_ff;
      paddr_in  = paddr_ff;
      rvol_in   = rvol_ff;
      need_in   = need_ff;
      avail_in  = avail_ff;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      cur_in    = cur_ff;
      lo_min_in = lo_min_ff;
      hi_max_in = hi_max_ff;
      sv_lo_in  = sv_lo_ff;
      sv_pb_in  = sv_pb_ff;
      snap_in   = snap_ff;
      vvalid_in = vvalid_ff;
      pvalid_in = pvalid_ff;
      v_we   = 1'b0;
      v_wa   = idx_ff;
      v_wlo  = item_ff.addr;
      v_whi  = item_ff.last;
      v_wpb  = item_ff.pbase;
      v_wvol = 32'd0;
      p_we   = 1'b0;
      p_wa   = pfree_idx;
      q_pop  = 1'b0;
      load   = 1'b0;
      unique case (state_ff)
         armt_pkg::S_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               item_in   = q_item;
               idx_in    = '0;
               status_in = (q_item.op == armt_pkg::OP_BAD) ? armt_pkg::ST_MISS
                                                           : armt_pkg::ST_OK;
               hit_in    = 1'b0;
               rlo_in    = 64'd0;
               rhi_in    = 64'd0;
               paddr_in  = 64'd0;
               rvol_in   = 32'd0;
               need_in   = '0;
               avail_in  = '0;
               step_in   = '0;
               cur_in    = q_item.addr;
               cnt_in    = '0;
               lo_min_in = armt_pkg::U64_MAX;
               hi_max_in = 64'd0;
            end
         end
         armt_pkg::S_ADD: begin
            if (!vfree_found || !pfree_found) begin
               status_in = armt_pkg::ST_FULL;
            end else begin
               v_we   = 1'b1;
               v_wa   = vfree_idx;
               v_wpb  = item_ff.addr;
               v_wvol = item_ff.vol;
               vvalid_in[vfree_idx] = 1'b1;
               p_we   = 1'b1;
               pvalid_in[pfree_idx] = 1'b1;
            end
         end
         armt_pkg::S_MAP_SCAN: begin
            if (rv && rl <= item_ff.last && rh >= item_ff.addr) begin
               status_in = armt_pkg::ST_OVERLAP;
            end
            idx_in = idx_next;
         end
         armt_pkg::S_MAP_WR: begin
            if (status_ff == armt_pkg::ST_OK) begin
               if (!vfree_found) begin
                  status_in = armt_pkg::ST_FULL;
               end else begin
                  v_we = 1'b1;
                  v_wa = vfree_idx;
                  vvalid_in[vfree_idx] = 1'b1;
               end
            end
         end
         armt_pkg::S_UM_COUNT: begin
            avail_in = avail_nx;
            need_in  = need_nx;
            snap_in  = vvalid_ff;
            idx_in   = idx_next;
            if (last_idx && need_nx > avail_nx) begin
               status_in = armt_pkg::ST_FULL;
            end
         end
         armt_pkg::S_UM_CUT: begin
            if (um_hit) begin
               if (rh > item_ff.last) begin
                  v_we  = 1'b1;
                  v_wlo = item_ff.last + 64'd1;
                  v_whi = rh;
                  v_wpb = rpb + (item_ff.last + 64'd1 - rl);
                  sv_lo_in = rl;
                  sv_pb_in = rpb;
               end else if (rl < item_ff.addr) begin
                  v_we  = 1'b1;
                  v_wlo = rl;
                  v_whi = item_ff.addr - 64'd1;
                  v_wpb = rpb;
               end else begin
                  vvalid_in[idx_ff] = 1'b0;
               end
            end
            if (!split) idx_in = idx_next;
         end
         armt_pkg::S_UM_SPLIT: begin
            if (vfree_found) begin
               v_we  = 1'b1;
               v_wa  = vfree_idx;
               v_wlo = sv_lo_ff;
               v_whi = item_ff.addr - 64'd1;
               v_wpb = sv_pb_ff;
               vvalid_in[vfree_idx] = 1'b1;
            end
            idx_in = idx_next;
         end
         armt_pkg::S_LOOK: begin
            if (look_hit) begin
               hit_in   = 1'b1;
               rlo_in   = rl;
               rhi_in   = rh;
               paddr_in = rpb + (item_ff.addr - rl);
               rvol_in  = rvl;
            end else if (last_idx) begin
               status_in = armt_pkg::ST_MISS;
            end
            idx_in = idx_next;
         end
         armt_pkg::S_CHK: begin
            if (c_hit) begin
               if (ch >= item_ff.last) begin
                  hit_in = 1'b1;
               end else if (step_ff == CW'(N)) begin
                  status_in = armt_pkg::ST_MISS;
               end else begin
                  cur_in  = ch + 64'd1;
                  step_in = step_ff + CW'(1);
                  idx_in  = '0;
               end
            end else begin
               if (last_idx) status_in = armt_pkg::ST_MISS;
               idx_in = idx_next;
            end
         end
         armt_pkg::S_BND: begin
            if (rv) begin
               cnt_in = cnt_ff + CW'(1);
               if (rl < lo_min_ff) lo_min_in = rl;
               if (rh > hi_max_ff) hi_max_in = rh;
            end
            idx_in = idx_next;
         end
         armt_pkg::S_OUT: begin
            load = out_free;
         end
         default: begin
         end
      endcase
      if (state_nx == armt_pkg::S_BND && state_ff != armt_pkg::S_BND) begin
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= armt_pkg::S_IDLE;
         idx_ff    <= '0;
         vvalid_ff <= '0;
         pvalid_ff <= '0;
      end else begin
         state_ff  <= state_nx;
         idx_ff    <= idx_in;
         vvalid_ff <= vvalid_in;
         pvalid_ff <= pvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
      rlo_ff    <= rlo_in;
      rhi_ff    <= rhi_in;
      paddr_ff  <= paddr_in;
      rvol_ff   <= rvol_in;
      need_ff   <= need_in;
      avail_ff  <= avail_in;
      step_ff   <= step_in;
      cnt_ff    <= cnt_in;
      cur_ff    <= cur_in;
      lo_min_ff <= lo_min_in;
      hi_max_ff <= hi_max_in;
      sv_lo_ff  <= sv_lo_in;
      sv_pb_ff  <= sv_pb_in;
      snap_ff   <= snap_in;
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         vlow[v_wa]  <= v_wlo;
         vhigh[v_wa] <= v_whi;
         vpb[v_wa]   <= v_wpb;
         vvol[v_wa]  <= v_wvol;
      end
      if (p_we) begin
         plow[p_wa]  <= item_ff.addr;
         phigh[p_wa] <= item_ff.last;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         o_status_ff <= status_ff;
         o_hit_ff    <= hit_ff;
         o_rlo_ff    <= rlo_ff;
         o_rhi_ff    <= rhi_ff;
         o_paddr_ff  <= paddr_ff;
         o_rvol_ff   <= rvol_ff;
         o_cnt_ff    <= 5'(cnt_ff);
         o_span_ff   <= (cnt_ff == '0) ? 64'd0 : (hi_max_ff - lo_min_ff + 64'd1);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = o_status_ff;
   assign rsp_hit           = o_hit_ff;
   assign rsp_region_low    = o_rlo_ff;
   assign rsp_region_high   = o_rhi_ff;
   assign rsp_phys_addr     = o_paddr_ff;
   assign rsp_region_volume = o_rvol_ff;
   assign rsp_region_count  = o_cnt_ff;
   assign rsp_span_bytes    = o_span_ff;

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("result not presented after load");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_hit_ff) |-> (o_status_ff == armt_pkg::ST_OK))
      else $error("hit with error status");

   a_split_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == armt_pkg::S_UM_SPLIT) |-> ($past(state_ff) == armt_pkg::S_UM_CUT))
      else $error("split without cut");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff != armt_pkg::S_IDLE))
      else $error("request popped but sequencer idle");

endmodule

/* sv/address_region_map_table.sv */
`timescale 1ns / 1ps
// Sequence per request, after the front register and the queue: the command's own
//   table walk (an unmap adds a split step per split region), then a bounds walk
//   over all N = MAX_REGIONS entries, then the output state, held while the result stalls.
// Throughput: one request at a time in the table sequencer; the closing bounds
//   walk over every entry sets the floor. Three more requests wait meanwhile.
// Reset: synchronous; clears all valid bits, queue and result register.
// ----------------------------------------------------------------------------
// address_region_map_table
// Virtual and physical region table with add, map, unmap, lookup and range check.
// ----------------------------------------------------------------------------
module address_region_map_table #(
   parameter int MAX_REGIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [63:0] req_addr_start,
   input  logic [63:0] req_length,
   input  logic [63:0] req_phys_base,
   input  logic [31:0] req_volume,
   input  logic        req_space,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_hit,
   output logic [63:0] rsp_region_low,
   output logic [63:0] rsp_region_high,
   output logic [63:0] rsp_phys_addr,
   output logic [31:0] rsp_region_volume,
   output logic [4:0]  rsp_region_count,
   output logic [63:0] rsp_span_bytes
);

   logic               push, full, pop, qv;
   armt_pkg::item_type push_item, q_item;

   armt_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_addr_start(req_addr_start),
      .req_length(req_length), .req_phys_base(req_phys_base),
      .req_volume(req_volume), .req_space(req_space),
      .q_push(push), .q_item(push_item), .q_full(full)
   );

   armt_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_item(push_item), .full(full),
      .pop(pop), .valid(qv), .item(q_item)
   );

   armt_back #(.N(MAX_REGIONS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(qv), .q_item(q_item), .q_pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_hit(rsp_hit),
      .rsp_region_low(rsp_region_low), .rsp_region_high(rsp_region_high),
      .rsp_phys_addr(rsp_phys_addr), .rsp_region_volume(rsp_region_volume),
      .rsp_region_count(rsp_region_count), .rsp_span_bytes(rsp_span_bytes)
   );

endmodule

/* verif/armt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// armt_checker
// Watches both channels, predicts each result from an own copy of the
// region tables and compares every response field against the prediction.
// ----------------------------------------------------------------------------
module armt_checker #(
   parameter int MAX_REGIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [63:0] req_addr_start,
   input  logic [63:0] req_length,
   input  logic [63:0] req_phys_base,
   input  logic [31:0] req_volume,
   input  logic        req_space,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_hit,
   input  logic [63:0] rsp_region_low,
   input  logic [63:0] rsp_region_high,
   input  logic [63:0] rsp_phys_addr,
   input  logic [31:0] rsp_region_volume,
   input  logic [4:0]  rsp_region_count,
   input  logic [63:0] rsp_span_bytes,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [63:0] rlo;
      logic [63:0] rhi;
      logic [63:0] paddr;
      logic [31:0] rvol;
      logic [4:0]  count;
      logic [63:0] span;
   } answer_type;

   answer_type answer_q[$];

   bit          v_ok[MAX_REGIONS];
   logic [63:0] v_lo[MAX_REGIONS];
   logic [63:0] v_hi[MAX_REGIONS];
   logic [63:0] v_pb[MAX_REGIONS];
   logic [31:0] v_vol[MAX_REGIONS];
   bit          p_ok[MAX_REGIONS];
   logic [63:0] p_lo[MAX_REGIONS];
   logic [63:0] p_hi[MAX_REGIONS];

   assign pending = answer_q.size();

   function automatic int first_free_virt();
      for (int i = 0; i < MAX_REGIONS; i++) if (!v_ok[i]) return i;
      return -1;
   endfunction

   function automatic int first_free_phys();
      for (int i = 0; i < MAX_REGIONS; i++) if (!p_ok[i]) return i;
      return -1;
   endfunction

   function automatic int find_slot(bit phys, logic [63:0] a);
      for (int i = 0; i < MAX_REGIONS; i++) begin
         if (phys && p_ok[i] && a >= p_lo[i] && a <= p_hi[i]) return i;
         if (!phys && v_ok[i] && a >= v_lo[i] && a <= v_hi[i]) return i;
      end
      return -1;
   endfunction

   function automatic bit range_covered(bit phys, logic [63:0] a, logic [63:0] len);
      logic [63:0] last, cur, hi;
      int k;
      if (len != 0 && len - 1 > armt_pkg::U64_MAX - a) return 1'b0;
      last = (len == 0) ? a : a + (len - 1);
      cur = a;
      for (int s = 0; s <= MAX_REGIONS; s++) begin
         k = find_slot(phys, cur);
         if (k < 0) return 1'b0;
         hi = phys ? p_hi[k] : v_hi[k];
         if (hi >= last) return 1'b1;
         cur = hi + 1;
      end
      return 1'b0;
   endfunction

   function automatic void put_virt(int k, logic [63:0] lo, logic [63:0] hi,
                                    logic [63:0] pb, logic [31:0] vol);
      v_ok[k] = 1; v_lo[k] = lo; v_hi[k] = hi; v_pb[k] = pb; v_vol[k] = vol;
   endfunction

   function automatic logic [1:0] cut_range(logic [63:0] start, logic [63:0] len);
      bit snap[MAX_REGIONS];
      logic [63:0] stop, lo, hi, pb;
      int need, avail, k;
      need = 0; avail = 0;
      if (len == 0) return armt_pkg::ST_OK;
      stop = (len - 1 > armt_pkg::U64_MAX - start) ? armt_pkg::U64_MAX
                                                    : start + (len - 1);
      for (int i = 0; i < MAX_REGIONS; i++) begin
         if (!v_ok[i]) avail++;
         else if (v_lo[i] < start && v_hi[i] > stop) need++;
      end
      if (need > avail) return armt_pkg::ST_FULL;
      snap = v_ok;
      for (int i = 0; i < MAX_REGIONS; i++) begin
         if (!snap[i]) continue;
         lo = v_lo[i]; hi = v_hi[i]; pb = v_pb[i];
         if (lo > stop || hi < start) continue;
         v_ok[i] = 0;
         if (hi > stop) put_virt(i, stop + 1, hi, pb + (stop + 1 - lo), 32'd0);
         if (lo < start) begin
            k = v_ok[i] ? first_free_virt() : i;
            if (k >= 0) put_virt(k, lo, start - 1, pb, 32'd0);
         end
      end
      return armt_pkg::ST_OK;
   endfunction

   function automatic answer_type predict_answer(logic [2:0] cmd, logic [63:0] a,
         logic [63:0] len, logic [63:0] pbase, logic [31:0] vol, logic space);
      answer_type r;
      logic [63:0] last, lowest, highest;
      int k, kp, n;
      r = '0;
      if ((cmd == armt_pkg::CMD_ADD || cmd == armt_pkg::CMD_MAP) && len != 0) begin
         if (len - 1 > armt_pkg::U64_MAX - a) r.status = armt_pkg::ST_MISS;
         else begin
            last = a + (len - 1);
            if (cmd == armt_pkg::CMD_ADD) begin
               k = first_free_virt();
               kp = first_free_phys();
               if (k < 0 || kp < 0) r.status = armt_pkg::ST_FULL;
               else begin
                  p_ok[kp] = 1; p_lo[kp] = a; p_hi[kp] = last;
                  put_virt(k, a, last, a, vol);
               end
            end else begin
               for (int i = 0; i < MAX_REGIONS; i++)
                  if (v_ok[i] && v_lo[i] <= last && v_hi[i] >= a)
                     r.status = armt_pkg::ST_OVERLAP;
               if (r.status == armt_pkg::ST_OK) begin
                  k = first_free_virt();
                  if (k < 0) r.status = armt_pkg::ST_FULL;
                  else put_virt(k, a, last, pbase, 32'd0);
               end
            end
         end
      end else if (cmd == armt_pkg::CMD_UNMAP) begin
         r.status = cut_range(a, len);
      end else if (cmd == armt_pkg::CMD_LOOKUP) begin
         k = find_slot(1'b0, a);
         if (k < 0) r.status = armt_pkg::ST_MISS;
         else begin
            r.hit = 1; r.rlo = v_lo[k]; r.rhi = v_hi[k];
            r.paddr = v_pb[k] + (a - v_lo[k]); r.rvol = v_vol[k];
         end
      end else if (cmd == armt_pkg::CMD_CHECK) begin
         r.hit = range_covered(space, a, len);
         r.status = r.hit ? armt_pkg::ST_OK : armt_pkg::ST_MISS;
      end else if (cmd > armt_pkg::CMD_CHECK) begin
         r.status = armt_pkg::ST_MISS;
      end
      lowest = armt_pkg::U64_MAX; highest = 0; n = 0;
      for (int i = 0; i < MAX_REGIONS; i++) if (v_ok[i]) begin
         n++;
         if (v_lo[i] < lowest) lowest = v_lo[i];
         if (v_hi[i] > highest) highest = v_hi[i];
      end
      r.count = n[4:0];
      r.span = (n == 0) ? 64'd0 : highest - lowest + 1;
      return r;
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         answer_q.delete();
         fail_count = 0;
         for (int i = 0; i < MAX_REGIONS; i++) begin
            v_ok[i] = 0; p_ok[i] = 0;
         end
      end else begin
         if (req_valid && !req_stall)
            answer_q.push_back(predict_answer(req_command, req_addr_start, req_length,
                                              req_phys_base, req_volume, req_space));
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               $display("%0t: response with no request outstanding", $time);
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               compare_field("status", want.status, rsp_status);
               compare_field("hit", want.hit, rsp_hit);
               compare_field("region_low", want.rlo, rsp_region_low);
               compare_field("region_high", want.rhi, rsp_region_high);
               compare_field("phys_addr", want.paddr, rsp_phys_addr);
               compare_field("region_volume", want.rvol, rsp_region_volume);
               compare_field("region_count", want.count, rsp_region_count);
               compare_field("span_bytes", want.span, rsp_span_bytes);
            end
         end
      end
   end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random table commands with random gaps and stalls,
// including a long response hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int N_RANDOM = 1600;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_command = armt_pkg::CMD_LOOKUP;
   logic [63:0] req_addr_start = 0;
   logic [63:0] req_length = 0;
   logic [63:0] req_phys_base = 0;
   logic [31:0] req_volume = 0;
   logic        req_space = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic        rsp_hit;
   logic [63:0] rsp_region_low;
   logic [63:0] rsp_region_high;
   logic [63:0] rsp_phys_addr;
   logic [31:0] rsp_region_volume;
   logic [4:0]  rsp_region_count;
   logic [63:0] rsp_span_bytes;
   int          fail_count;
   int          pending;
   bit          long_hold = 0;
   bit          stim_done = 0;

   always #5 clock = ~clock;

   address_region_map_table dut (.*);
   armt_checker chk (.*);

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_request(logic [2:0] cmd, logic [63:0] a, logic [63:0] len,
                               logic [63:0] pb, logic [31:0] vol, logic sp);
      req_valid      <= 1;
      req_command    <= cmd;
      req_addr_start <= a;
      req_length     <= len;
      req_phys_base  <= pb;
      req_volume     <= vol;
      req_space      <= sp;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_sender();
      int g;
      g = (long_hold) ? 0 : gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   // small address window so regions collide often
   function automatic logic [63:0] near_addr();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return armt_pkg::U64_MAX - $urandom_range(0, 600);
      if (r == 1) return rand64();
      return 64'h1000 + $urandom_range(0, 4095);
   endfunction

   function automatic logic [63:0] near_len();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return rand64();
      if (r == 2) return armt_pkg::U64_MAX;
      return $urandom_range(1, 1200);
   endfunction

   task automatic random_request();
      logic [2:0] cmd;
      int r;
      r = $urandom_range(0, 99);
      if (r < 22) cmd = armt_pkg::CMD_ADD;
      else if (r < 40) cmd = armt_pkg::CMD_MAP;
      else if (r < 58) cmd = armt_pkg::CMD_UNMAP;
      else if (r < 78) cmd = armt_pkg::CMD_LOOKUP;
      else if (r < 97) cmd = armt_pkg::CMD_CHECK;
      else cmd = 3'($urandom_range(5, 7));
      send_request(cmd, near_addr(), near_len(), rand64(), $urandom, 1'($urandom));
   endtask

   // response side: random stalls, one long hold-off
   initial begin
      int g;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
            rsp_stall <= 0;
            wait (!long_hold);
         end else if ($urandom_range(0, 3) == 0) begin
            g = gap_len();
            rsp_stall <= (g > 0);
            repeat (g) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send_request(armt_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0);
      send_request(armt_pkg::CMD_ADD, 64'h100, 0, 0, 32'h1, 0);
      send_request(armt_pkg::CMD_ADD, armt_pkg::U64_MAX, 2, 0, 32'h2, 0);
      send_request(armt_pkg::CMD_ADD, 64'h1000, 64'h100, 0, 32'hFFFF_FFFF, 0);
      send_request(armt_pkg::CMD_MAP, 64'h1080, 64'h10, 64'h9000, 0, 0);
      send_request(armt_pkg::CMD_MAP, 64'h2000, 64'h100, armt_pkg::U64_MAX, 0, 0);
      send_request(armt_pkg::CMD_MAP, 64'h3000, 0, 64'h5, 0, 0);
      send_request(armt_pkg::CMD_ADD, armt_pkg::U64_MAX, 1, 0, 32'h3, 0);
      send_request(armt_pkg::CMD_LOOKUP, 64'h1010, 0, 0, 0, 1);
      send_request(armt_pkg::CMD_LOOKUP, 64'h2050, 0, 0, 0, 0);
      send_request(armt_pkg::CMD_LOOKUP, 64'h5000, 0, 0, 0, 0);
      send_request(armt_pkg::CMD_CHECK, 64'h1000, 64'h100, 0, 0, 0);
      send_request(armt_pkg::CMD_CHECK, 64'h1000, 64'h200, 0, 0, 1);
      send_request(armt_pkg::CMD_CHECK, 64'h1000, 0, 0, 0, 1);
      send_request(armt_pkg::CMD_CHECK, 64'h10, armt_pkg::U64_MAX, 0, 0, 0);
      send_request(armt_pkg::CMD_UNMAP, 64'h1040, 64'h10, 0, 0, 0);
      send_request(armt_pkg::CMD_UNMAP, 64'h1000, 0, 0, 0, 0);
      send_request(armt_pkg::CMD_LOOKUP, 64'h1060, 0, 0, 0, 0);
      send_request(3'd7, rand64(), rand64(), rand64(), $urandom, 1);
      send_request(armt_pkg::CMD_ADD, 0, armt_pkg::U64_MAX, 0, 32'h4, 0);
      send_request(armt_pkg::CMD_LOOKUP, armt_pkg::U64_MAX - 1, 0, 0, 0, 0);
      for (int i = 0; i < 16; i++)
         send_request(armt_pkg::CMD_MAP, 64'h10000 * (i + 1), 64'h10, 0, 0, 0);
      send_request(armt_pkg::CMD_UNMAP, 64'h10, armt_pkg::U64_MAX, 0, 0, 0);
      send_request(armt_pkg::CMD_UNMAP, 0, armt_pkg::U64_MAX, 0, 0, 0);
      // random, with one long response hold-off in the middle
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 400) long_hold = 1;
         if (i == 420) long_hold = 0;
         if ($urandom_range(0, 199) == 0)
            send_request(armt_pkg::CMD_UNMAP, 0, armt_pkg::U64_MAX, 0, 0, 0);
         else
            random_request();
         pause_sender();
      end
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      repeat (2) @(posedge clock);
      wait (pending == 0);
      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("** address_region_map_table: PASSED **");
      else
         $display("** address_region_map_table: FAILED **");
      $finish;
   end

   initial begin
      #20ms;
      $display("** address_region_map_table: FAILED **");
      $finish;
   end

endmodule
